@@ src/tcm_pkg.sv @@
`timescale 1ns / 1ps

package tcm_pkg;

  // Widths of the fields and registers
  localparam int RPM_W      = 14;
  localparam int LIMIT_W    = 20;
  localparam int RATIO_W    = 17;
  localparam int TRATIO_W   = 14;
  localparam int TT_W       = 22;
  localparam int CAP_W      = 32;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int NPTS       = 16;

  localparam logic [RATIO_W-1:0]  ONE_Q16 = 17'd65536;
  localparam logic [TRATIO_W-1:0] ONE_Q12 = 14'd4096;

  // Reset values of the configuration registers
  localparam logic [TRATIO_W-1:0] STALL_RESET = 14'd8192;
  localparam logic [CAP_W-1:0]    CAP_RESET   = 32'd42950;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STALL_RATIO = 1'b0,
    REG_CAPACITY    = 1'b1
  } cfg_reg_t;

  // Torque multiplication curve: speed points in Q1.16, torque points in Q2.12
  localparam logic [RATIO_W-1:0] SPEED_PTS [NPTS] = '{
    17'd0,     17'd6554,  17'd13107, 17'd19661, 17'd26214, 17'd32768,
    17'd39322, 17'd45875, 17'd52429, 17'd55706, 17'd58982, 17'd60293,
    17'd61604, 17'd62915, 17'd63570, 17'd65536
  };
  localparam logic [TRATIO_W-1:0] TORQUE_PTS [NPTS] = '{
    14'd8192, 14'd7578, 14'd6963, 14'd6349, 14'd5734, 14'd5120,
    14'd4588, 14'd4178, 14'd4096, 14'd4096, 14'd4096, 14'd4096,
    14'd4096, 14'd4096, 14'd4096, 14'd4096
  };

  // Partial state of the speed ratio divider
  typedef struct packed {
    logic [RPM_W-1:0] rem;
    logic [15:0]      quo;
  } rdiv_t;

  // Partial state of the segment interpolation divider
  typedef struct packed {
    logic [12:0] rem;
    logic [9:0]  quo;
    logic [9:0]  low;
  } idiv_t;

  // Width of segment seg on the speed axis
  function automatic logic [12:0] seg_ds(input logic [3:0] seg);
    logic [3:0] nx;
    nx = seg + 4'd1;
    return 13'(SPEED_PTS[nx] - SPEED_PTS[seg]);
  endfunction

  // Torque drop across segment seg
  function automatic logic [9:0] seg_dt(input logic [3:0] seg);
    logic [3:0] nx;
    nx = seg + 4'd1;
    return 10'(TORQUE_PTS[seg] - TORQUE_PTS[nx]);
  endfunction

  // Four restoring steps of turbine * 2^16 / engine
  function automatic rdiv_t ratio_div4(input rdiv_t s, input logic [RPM_W-1:0] d);
    rdiv_t             r;
    logic [RPM_W:0]    t;
    r = s;
    for (int k = 0; k < 4; k++) begin
      t = {r.rem, 1'b0};
      if (t >= {1'b0, d}) begin
        r.rem = RPM_W'(t - {1'b0, d});
        r.quo = {r.quo[14:0], 1'b1};
      end else begin
        r.rem = t[RPM_W-1:0];
        r.quo = {r.quo[14:0], 1'b0};
      end
    end
    return r;
  endfunction

  // Five restoring steps of the interpolation quotient
  function automatic idiv_t interp_div5(input idiv_t s, input logic [12:0] d);
    idiv_t       r;
    logic [13:0] t;
    r = s;
    for (int k = 0; k < 5; k++) begin
      t = {r.rem, r.low[9]};
      r.low = {r.low[8:0], 1'b0};
      if (t >= {1'b0, d}) begin
        r.rem = 13'(t - {1'b0, d});
        r.quo = {r.quo[8:0], 1'b1};
      end else begin
        r.rem = t[12:0];
        r.quo = {r.quo[8:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

@@ src/torque_converter_model.sv @@
`timescale 1ns / 1ps

// Torque converter model, one result transaction per input transaction.
// Input channel: item_valid / item_stall with engine_rpm, turbine_rpm and
// torque_limit. Output channel: result_valid / result_stall with
// speed_ratio, slip, torque_ratio, applied_torque and turb_torque.
// Configuration: cfg_write with cfg_index selects stall_torque_ratio (0) or
// capacity_factor (1); write only while no transaction is in flight.
// Throughput: one transaction per cycle while result_stall is low. The
// depth is set by the 16-bit restoring divider for the speed ratio (four
// stages of four steps), the segment divider of the curve interpolation
// (two stages) and the capacity and torque multipliers, each followed by a
// register.
// Reset (rst, synchronous): the pipeline empties and the registers return
// to 2.0 stall ratio and K = 42950.
// Result stall: the last stage holds its transaction; empty stages further
// up still fill, so inputs are taken until the pipeline is full.
module torque_converter_model
  import tcm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  logic signed [14:0]    engine_rpm,
  input  logic signed [14:0]    turbine_rpm,
  input  logic [LIMIT_W-1:0]    torque_limit,
  output logic                  result_valid,
  input  logic                  result_stall,
  output logic [RATIO_W-1:0]    speed_ratio,
  output logic [RATIO_W-1:0]    slip,
  output logic [TRATIO_W-1:0]   torque_ratio,
  output logic [LIMIT_W-1:0]    applied_torque,
  output logic [TT_W-1:0]       turb_torque
);

  localparam int NSTG = 12;

  typedef struct packed {
    logic [RPM_W-1:0]    eng;
    logic [LIMIT_W-1:0]  limit;
    logic                eng_zero;
    logic                tur_ge;
    logic [27:0]         esq;
    rdiv_t               dv;
    logic [59:0]         cap_prod;
    logic [LIMIT_W-1:0]  applied;
    logic [RATIO_W-1:0]  ratio;
    logic [RATIO_W-1:0]  slip;
    logic [3:0]          seg;
    logic [12:0]         offs;
    idiv_t               iv;
    logic                stall_up;
    logic [26:0]         sprod;
    logic [TRATIO_W-1:0] tr;
    logic [TT_W-1:0]     tt;
  } pipe_t;

  logic [TRATIO_W-1:0] stall_ratio;
  logic [CAP_W-1:0]    cap_factor;

  pipe_t            pipe      [1:NSTG];
  pipe_t            pipe_next [1:NSTG];
  logic [NSTG:1]    vld;
  logic [NSTG+1:1]  rdy;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      stall_ratio <= STALL_RESET;
      cap_factor  <= CAP_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_STALL_RATIO: stall_ratio <= cfg_data[TRATIO_W-1:0];
        REG_CAPACITY:    cap_factor  <= cfg_data[CAP_W-1:0];
      endcase
    end
  end

  // A stage takes new data when it is empty or its content moves on
  always_comb begin
    rdy[NSTG+1] = !result_stall;
    for (int k = NSTG; k >= 1; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign item_stall = !rdy[1];

  // Stage logic
  always_comb begin
    logic [RPM_W-1:0]    eng_c;
    logic [RPM_W-1:0]    tur_c;
    logic [31:0]         cap;
    logic [RATIO_W-1:0]  ratio_v;
    logic [3:0]          seg_v;
    logic [22:0]         iprod;
    logic [TRATIO_W-1:0] base;
    logic [12:0]         excess;
    logic [TRATIO_W-1:0] sdiff;
    logic [14:0]         tr_w;
    logic [33:0]         tprod;

    // Clamp speeds, square the engine speed, seed the ratio divider
    eng_c = engine_rpm[14]  ? '0 : engine_rpm[RPM_W-1:0];
    tur_c = turbine_rpm[14] ? '0 : turbine_rpm[RPM_W-1:0];
    pipe_next[1]          = '0;
    pipe_next[1].eng      = eng_c;
    pipe_next[1].limit    = torque_limit;
    pipe_next[1].eng_zero = (eng_c == '0);
    pipe_next[1].tur_ge   = (tur_c >= eng_c);
    pipe_next[1].esq      = {14'b0, eng_c} * {14'b0, eng_c};
    pipe_next[1].dv.rem   = tur_c;
    pipe_next[1].dv.quo   = '0;

    // Divider steps and capacity product K * N^2
    pipe_next[2]          = pipe[1];
    pipe_next[2].dv       = ratio_div4(pipe[1].dv, pipe[1].eng);
    pipe_next[2].cap_prod = {28'b0, cap_factor} * {32'b0, pipe[1].esq};

    // Divider steps; applied torque is the smaller of capacity and limit
    cap = pipe[2].cap_prod[59:28];
    pipe_next[3]         = pipe[2];
    pipe_next[3].dv      = ratio_div4(pipe[2].dv, pipe[2].eng);
    pipe_next[3].applied = (cap < {12'b0, pipe[2].limit}) ? cap[LIMIT_W-1:0]
                                                          : pipe[2].limit;

    pipe_next[4]    = pipe[3];
    pipe_next[4].dv = ratio_div4(pipe[3].dv, pipe[3].eng);

    pipe_next[5]    = pipe[4];
    pipe_next[5].dv = ratio_div4(pipe[4].dv, pipe[4].eng);

    // Select the ratio and find the first bracketing curve segment
    if (pipe[5].eng_zero) begin
      ratio_v = '0;
    end else if (pipe[5].tur_ge) begin
      ratio_v = ONE_Q16;
    end else begin
      ratio_v = {1'b0, pipe[5].dv.quo};
    end
    seg_v = 4'(NPTS - 2);
    for (int i = NPTS - 2; i >= 0; i--) begin
      if (ratio_v >= SPEED_PTS[i] && ratio_v <= SPEED_PTS[i+1]) begin
        seg_v = 4'(i);
      end
    end
    pipe_next[6]       = pipe[5];
    pipe_next[6].ratio = ratio_v;
    pipe_next[6].slip  = ONE_Q16 - ratio_v;
    pipe_next[6].seg   = seg_v;
    pipe_next[6].offs  = 13'(ratio_v - SPEED_PTS[seg_v]);

    // Torque drop times offset into the segment; seed the segment divider
    iprod = {13'b0, seg_dt(pipe[6].seg)} * {10'b0, pipe[6].offs};
    pipe_next[7]        = pipe[6];
    pipe_next[7].iv.rem = {1'b0, iprod[21:10]};
    pipe_next[7].iv.low = iprod[9:0];
    pipe_next[7].iv.quo = '0;

    pipe_next[8]    = pipe[7];
    pipe_next[8].iv = interp_div5(pipe[7].iv, seg_ds(pipe[7].seg));

    pipe_next[9]    = pipe[8];
    pipe_next[9].iv = interp_div5(pipe[8].iv, seg_ds(pipe[8].seg));

    // Curve value and its excess over 1.0 scaled by the stall ratio's distance from 1.0
    base   = TORQUE_PTS[pipe[9].seg] - {4'b0, pipe[9].iv.quo};
    excess = 13'(base - ONE_Q12);
    sdiff  = (stall_ratio >= ONE_Q12) ? stall_ratio - ONE_Q12 : ONE_Q12 - stall_ratio;
    pipe_next[10]          = pipe[9];
    pipe_next[10].stall_up = (stall_ratio >= ONE_Q12);
    pipe_next[10].sprod    = {14'b0, excess} * {13'b0, sdiff};

    // Scaled torque ratio, truncated toward 1.0
    if (pipe[10].stall_up) begin
      tr_w = {1'b0, ONE_Q12} + pipe[10].sprod[26:12];
    end else begin
      tr_w = {1'b0, ONE_Q12} - pipe[10].sprod[26:12];
    end
    pipe_next[11]    = pipe[10];
    pipe_next[11].tr = tr_w[TRATIO_W-1:0];

    // Turbine torque; a 20 by 14 bit product over 2^12 cannot pass 2^22 - 1
    tprod = {14'b0, pipe[11].applied} * {20'b0, pipe[11].tr};
    pipe_next[12]    = pipe[11];
    pipe_next[12].tt = tprod[33:12];
  end

  // Advance valid bits and payload stage by stage
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[1]) begin
        vld[1] <= item_valid;
      end
      for (int k = 2; k <= NSTG; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1] && item_valid) begin
      pipe[1] <= pipe_next[1];
    end
    for (int k = 2; k <= NSTG; k++) begin
      if (rdy[k] && vld[k-1]) begin
        pipe[k] <= pipe_next[k];
      end
    end
  end

  // Drive the result channel from the last stage
  assign result_valid   = vld[NSTG];
  assign speed_ratio    = pipe[NSTG].ratio;
  assign slip           = pipe[NSTG].slip;
  assign torque_ratio   = pipe[NSTG].tr;
  assign applied_torque = pipe[NSTG].applied;
  assign turb_torque    = pipe[NSTG].tt;

`ifndef NO_ASSERTIONS
  a_take_input: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> vld[1])
    else $error("accepted transaction did not enter the first stage");

  a_ratio_rem: assert property (@(posedge clk) disable iff (rst)
    (vld[5] && !pipe[5].eng_zero && !pipe[5].tur_ge) |-> (pipe[5].dv.rem < pipe[5].eng))
    else $error("speed ratio divider remainder out of range");

  a_interp_rem: assert property (@(posedge clk) disable iff (rst)
    vld[9] |-> (pipe[9].iv.rem < seg_ds(pipe[9].seg)))
    else $error("interpolation divider remainder out of range");

  a_ratio_slip: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (speed_ratio <= ONE_Q16 && slip == ONE_Q16 - speed_ratio))
    else $error("speed ratio and slip disagree");

  a_applied: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (pipe[NSTG].applied <= pipe[NSTG].limit))
    else $error("applied torque above limit");
`endif

endmodule
